// ===== rtl/tsdt_pkg.sv =====
`default_nettype none

package tsdt_pkg;

   localparam int TIME_BITS     = 32;
   localparam int DIST_BITS     = 10;
   localparam int WINDOW_BITS   = 16;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = 3;

   localparam logic [CSR_IDX_BITS-1:0] REG_SWIPE_THRESHOLD   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_SWIPE_MAX_TIME    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_TAP_MAX_INTERVAL  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_TAP_MAX_DISTANCE  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_ROTATED_HALF_TURN = 3'd4;

   localparam logic [DIST_BITS-1:0]   SWIPE_THRESHOLD_RST  = 10'd60;
   localparam logic [WINDOW_BITS-1:0] SWIPE_MAX_TIME_RST   = 16'd500;
   localparam logic [WINDOW_BITS-1:0] TAP_MAX_INTERVAL_RST = 16'd400;
   localparam logic [DIST_BITS-1:0]   TAP_MAX_DISTANCE_RST = 10'd40;

   typedef struct packed {
      logic [DIST_BITS-1:0]   swipe_threshold;
      logic [WINDOW_BITS-1:0] swipe_max_time;
      logic [WINDOW_BITS-1:0] tap_max_interval;
      logic [DIST_BITS-1:0]   tap_max_distance;
      logic                   rotated_half_turn;
   } cfg_type;

   typedef struct packed {
      logic pressed;
      logic wake;
      logic enter_art;
      logic exit_art;
   } gesture_flags_type;

endpackage

`default_nettype wire

// ===== rtl/tsdt_req_if.sv =====
`default_nettype none

interface tsdt_req_if #(
   parameter int COORD_BITS = 10
);
   logic                             valid;
   logic                             ready;
   logic                             touch_down;
   logic [COORD_BITS-1:0]            touch_x;
   logic [COORD_BITS-1:0]            touch_y;
   logic [tsdt_pkg::TIME_BITS-1:0]   now_ms;
   logic                             display_normal;
   logic                             art_mode_active;
   logic                             touch_suppressed;
   logic                             art_ready;

   modport source (
      output valid, touch_down, touch_x, touch_y, now_ms,
             display_normal, art_mode_active, touch_suppressed, art_ready,
      input  ready
   );

   modport sink (
      input  valid, touch_down, touch_x, touch_y, now_ms,
             display_normal, art_mode_active, touch_suppressed, art_ready,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/tsdt_rsp_if.sv =====
`default_nettype none

interface tsdt_rsp_if #(
   parameter int COORD_BITS = 10
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] report_x;
   logic [COORD_BITS-1:0] report_y;
   logic                  report_pressed;
   logic                  wake_request;
   logic                  enter_art_request;
   logic                  exit_art_request;

   modport source (
      output valid, report_x, report_y, report_pressed, wake_request,
             enter_art_request, exit_art_request,
      input  ready
   );

   modport sink (
      input  valid, report_x, report_y, report_pressed, wake_request,
             enter_art_request, exit_art_request,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/tsdt_csr.sv =====
`default_nettype none

module tsdt_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [tsdt_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [tsdt_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic      [tsdt_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                     csr_pready,
   output tsdt_pkg::cfg_type                        cfg
);

   tsdt_pkg::cfg_type                   cfg_ff;
   tsdt_pkg::cfg_type                   cfg_in;
   logic [tsdt_pkg::CSR_IDX_BITS-1:0]   index;
   logic                                wr_en;

   assign index      = csr_paddr[tsdt_pkg::CSR_ADDR_BITS-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            tsdt_pkg::REG_SWIPE_THRESHOLD: begin
               cfg_in.swipe_threshold = csr_pwdata[tsdt_pkg::DIST_BITS-1:0];
            end
            tsdt_pkg::REG_SWIPE_MAX_TIME: begin
               cfg_in.swipe_max_time = csr_pwdata[tsdt_pkg::WINDOW_BITS-1:0];
            end
            tsdt_pkg::REG_TAP_MAX_INTERVAL: begin
               cfg_in.tap_max_interval = csr_pwdata[tsdt_pkg::WINDOW_BITS-1:0];
            end
            tsdt_pkg::REG_TAP_MAX_DISTANCE: begin
               cfg_in.tap_max_distance = csr_pwdata[tsdt_pkg::DIST_BITS-1:0];
            end
            tsdt_pkg::REG_ROTATED_HALF_TURN: begin
               cfg_in.rotated_half_turn = csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (index)
         tsdt_pkg::REG_SWIPE_THRESHOLD:
            csr_prdata = tsdt_pkg::CSR_DATA_BITS'(cfg_ff.swipe_threshold);
         tsdt_pkg::REG_SWIPE_MAX_TIME:
            csr_prdata = tsdt_pkg::CSR_DATA_BITS'(cfg_ff.swipe_max_time);
         tsdt_pkg::REG_TAP_MAX_INTERVAL:
            csr_prdata = tsdt_pkg::CSR_DATA_BITS'(cfg_ff.tap_max_interval);
         tsdt_pkg::REG_TAP_MAX_DISTANCE:
            csr_prdata = tsdt_pkg::CSR_DATA_BITS'(cfg_ff.tap_max_distance);
         tsdt_pkg::REG_ROTATED_HALF_TURN:
            csr_prdata = tsdt_pkg::CSR_DATA_BITS'(cfg_ff.rotated_half_turn);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.swipe_threshold   <= tsdt_pkg::SWIPE_THRESHOLD_RST;
         cfg_ff.swipe_max_time    <= tsdt_pkg::SWIPE_MAX_TIME_RST;
         cfg_ff.tap_max_interval  <= tsdt_pkg::TAP_MAX_INTERVAL_RST;
         cfg_ff.tap_max_distance  <= tsdt_pkg::TAP_MAX_DISTANCE_RST;
         cfg_ff.rotated_half_turn <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tsdt_gesture.sv =====
`default_nettype none

module tsdt_gesture #(
   parameter int COORD_BITS = 10
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              step_en,
   input  wire tsdt_pkg::cfg_type                 cfg,
   input  wire logic                              touch_down,
   input  wire logic [COORD_BITS-1:0]             touch_x,
   input  wire logic [COORD_BITS-1:0]             touch_y,
   input  wire logic [tsdt_pkg::TIME_BITS-1:0]    now_ms,
   input  wire logic                              display_normal,
   input  wire logic                              art_mode_active,
   input  wire logic                              touch_suppressed,
   input  wire logic                              art_ready,
   output logic      [COORD_BITS-1:0]             report_x,
   output logic      [COORD_BITS-1:0]             report_y,
   output tsdt_pkg::gesture_flags_type            flags
);

   localparam int CMP_BITS = (COORD_BITS > tsdt_pkg::DIST_BITS) ?
                             COORD_BITS : tsdt_pkg::DIST_BITS;

   logic                            tracking_ff, tracking_in;
   logic [COORD_BITS-1:0]           start_x_ff, start_x_in;
   logic [COORD_BITS-1:0]           start_y_ff, start_y_in;
   logic [tsdt_pkg::TIME_BITS-1:0]  start_time_ff, start_time_in;
   logic [COORD_BITS-1:0]           last_x_ff, last_x_in;
   logic [COORD_BITS-1:0]           last_y_ff, last_y_in;
   logic [tsdt_pkg::TIME_BITS-1:0]  tap_time_ff, tap_time_in;
   logic [COORD_BITS-1:0]           tap_x_ff, tap_x_in;
   logic [COORD_BITS-1:0]           tap_y_ff, tap_y_in;

   logic [tsdt_pkg::TIME_BITS-1:0]  elapsed;
   logic [tsdt_pkg::TIME_BITS-1:0]  gap;
   logic [COORD_BITS-1:0]           adx, ady, tdx, tdy;
   logic [CMP_BITS-1:0]             adx_w, ady_w, tdx_w, tdy_w, lim_w, tdist_w;
   logic                            dy_up;
   logic                            in_window, dominant, far;
   logic                            small_move, near_tap, in_interval;

   // magnitudes of the moves within the contact and from the stored tap
   assign adx = (last_x_ff >= start_x_ff) ? last_x_ff - start_x_ff
                                          : start_x_ff - last_x_ff;
   assign ady = (last_y_ff >= start_y_ff) ? last_y_ff - start_y_ff
                                          : start_y_ff - last_y_ff;
   assign tdx = (last_x_ff >= tap_x_ff) ? last_x_ff - tap_x_ff
                                        : tap_x_ff - last_x_ff;
   assign tdy = (last_y_ff >= tap_y_ff) ? last_y_ff - tap_y_ff
                                        : tap_y_ff - last_y_ff;

   assign adx_w   = CMP_BITS'(adx);
   assign ady_w   = CMP_BITS'(ady);
   assign tdx_w   = CMP_BITS'(tdx);
   assign tdy_w   = CMP_BITS'(tdy);
   assign lim_w   = CMP_BITS'(cfg.swipe_threshold);
   assign tdist_w = CMP_BITS'(cfg.tap_max_distance);

   // upward move after the half-turn correction
   assign dy_up = (last_y_ff < start_y_ff) ^ cfg.rotated_half_turn;

   assign elapsed     = now_ms - start_time_ff;
   assign gap         = now_ms - tap_time_ff;
   assign in_window   = elapsed < tsdt_pkg::TIME_BITS'(cfg.swipe_max_time);
   assign in_interval = gap < tsdt_pkg::TIME_BITS'(cfg.tap_max_interval);
   assign dominant    = ady_w > adx_w;
   assign far         = ady_w > lim_w;
   assign small_move  = !art_mode_active && (adx_w < tdist_w) && (ady_w < tdist_w);
   assign near_tap    = (tdx_w < tdist_w) && (tdy_w < tdist_w);

   always_comb begin
      tracking_in   = tracking_ff;
      start_x_in    = start_x_ff;
      start_y_in    = start_y_ff;
      start_time_in = start_time_ff;
      last_x_in     = last_x_ff;
      last_y_in     = last_y_ff;
      tap_time_in   = tap_time_ff;
      tap_x_in      = tap_x_ff;
      tap_y_in      = tap_y_ff;
      flags         = '0;
      if (touch_down) begin
         if (!tracking_ff) begin
            start_x_in    = touch_x;
            start_y_in    = touch_y;
            start_time_in = now_ms;
            tracking_in   = 1'b1;
         end
         last_x_in = touch_x;
         last_y_in = touch_y;
         if (!display_normal) begin
            flags.wake = 1'b1;
         end else if (!touch_suppressed) begin
            flags.wake    = 1'b1;
            flags.pressed = 1'b1;
         end
      end else if (tracking_ff) begin
         tracking_in = 1'b0;
         if (in_window) begin
            priority if (far && dominant && dy_up) begin
               flags.enter_art = art_ready;
            end else if (far && dominant) begin
               flags.exit_art = 1'b1;
            end else if (small_move) begin
               if (in_interval && near_tap) begin
                  flags.enter_art = art_ready;
                  tap_time_in     = '0;
               end else begin
                  tap_time_in = now_ms;
                  tap_x_in    = last_x_ff;
                  tap_y_in    = last_y_ff;
               end
            end
         end
      end
   end

   assign report_x = last_x_in;
   assign report_y = last_y_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tracking_ff   <= 1'b0;
         start_x_ff    <= '0;
         start_y_ff    <= '0;
         start_time_ff <= '0;
         last_x_ff     <= '0;
         last_y_ff     <= '0;
         tap_time_ff   <= '0;
         tap_x_ff      <= '0;
         tap_y_ff      <= '0;
      end else if (step_en) begin
         tracking_ff   <= tracking_in;
         start_x_ff    <= start_x_in;
         start_y_ff    <= start_y_in;
         start_time_ff <= start_time_in;
         last_x_ff     <= last_x_in;
         last_y_ff     <= last_y_in;
         tap_time_ff   <= tap_time_in;
         tap_x_ff      <= tap_x_in;
         tap_y_ff      <= tap_y_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/touch_swipe_double_tap_detector.sv =====
// channel   direction  payload
// req_ch    in         touch poll: touch flag, x, y, time in ms, display status flags
// rsp_ch    out        report x, y, pressed, wake, enter and exit art requests
// csr_*     in         apb register writes and reads, pready tied high
//
// one result per poll; the poll is registered at the input, the result at the output
// a poll can be taken every cycle while rsp_ch is not stalled; the gesture state updates in one pass
// reset (synchronous) restores register defaults and clears all gesture state
// while a result waits on rsp_ch.ready one more poll is held, then req_ch.ready drops
`default_nettype none

module touch_swipe_double_tap_detector #(
   parameter int COORD_BITS = 10
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   tsdt_req_if.sink                                 req_ch,
   tsdt_rsp_if.source                               rsp_ch,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [tsdt_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [tsdt_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic      [tsdt_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                     csr_pready
);

   tsdt_pkg::cfg_type               cfg;
   tsdt_pkg::gesture_flags_type     flags;
   tsdt_pkg::gesture_flags_type     flags_ff;

   logic                            in_valid_ff, in_valid_in;
   logic                            out_valid_ff, out_valid_in;
   logic                            advance, take_in;

   logic                            touch_down_ff;
   logic [COORD_BITS-1:0]           touch_x_ff, touch_y_ff;
   logic [tsdt_pkg::TIME_BITS-1:0]  now_ms_ff;
   logic                            display_normal_ff, art_mode_active_ff;
   logic                            touch_suppressed_ff, art_ready_ff;

   logic [COORD_BITS-1:0]           report_x, report_y;
   logic [COORD_BITS-1:0]           report_x_ff, report_y_ff;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign take_in      = req_ch.valid && req_ch.ready;

   assign in_valid_in  = take_in ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1
                                 : ((rsp_ch.valid && rsp_ch.ready) ? 1'b0 : out_valid_ff);

   tsdt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tsdt_gesture #(
      .COORD_BITS (COORD_BITS)
   ) u_gesture (
      .clock            (clock),
      .reset            (reset),
      .step_en          (advance),
      .cfg              (cfg),
      .touch_down       (touch_down_ff),
      .touch_x          (touch_x_ff),
      .touch_y          (touch_y_ff),
      .now_ms           (now_ms_ff),
      .display_normal   (display_normal_ff),
      .art_mode_active  (art_mode_active_ff),
      .touch_suppressed (touch_suppressed_ff),
      .art_ready        (art_ready_ff),
      .report_x         (report_x),
      .report_y         (report_y),
      .flags            (flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         touch_down_ff       <= req_ch.touch_down;
         touch_x_ff          <= req_ch.touch_x;
         touch_y_ff          <= req_ch.touch_y;
         now_ms_ff           <= req_ch.now_ms;
         display_normal_ff   <= req_ch.display_normal;
         art_mode_active_ff  <= req_ch.art_mode_active;
         touch_suppressed_ff <= req_ch.touch_suppressed;
         art_ready_ff        <= req_ch.art_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         report_x_ff <= report_x;
         report_y_ff <= report_y;
         flags_ff    <= flags;
      end
   end

   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.report_x          = report_x_ff;
   assign rsp_ch.report_y          = report_y_ff;
   assign rsp_ch.report_pressed    = flags_ff.pressed;
   assign rsp_ch.wake_request      = flags_ff.wake;
   assign rsp_ch.enter_art_request = flags_ff.enter_art;
   assign rsp_ch.exit_art_request  = flags_ff.exit_art;

endmodule

`default_nettype wire
